FILE: sv/bpa_pkg.sv
package bpa_pkg;

   localparam int OP_WIDTH     = 2;
   localparam int INDEX_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 17;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RESERVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_RUN      = 2'd1,
      STATUS_BAD_RANGE   = 2'd2,
      STATUS_DOUBLE_FREE = 2'd3
   } status_type;

   localparam logic [COUNT_WIDTH-1:0] MANAGED_RESET = 17'd65536;

endpackage

FILE: sv/bpa_req_if.sv
interface bpa_req_if;
   import bpa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    operation;
   logic [INDEX_WIDTH-1:0] start_page;
   logic [COUNT_WIDTH-1:0] page_count;
   modport source (output valid, operation, start_page, page_count, input ready);
   modport sink   (input valid, operation, start_page, page_count, output ready);
endinterface

FILE: sv/bpa_rsp_if.sv
interface bpa_rsp_if;
   import bpa_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [INDEX_WIDTH-1:0]  first_page;
   logic [COUNT_WIDTH-1:0]  free_pages;
   modport source (output valid, status, first_page, free_pages, input ready);
   modport sink   (input valid, status, first_page, free_pages, output ready);
endinterface

FILE: sv/bpa_csr_if.sv
interface bpa_csr_if;
   import bpa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] managed_pages;
   modport source (output valid, managed_pages, input ready);
   modport sink   (input valid, managed_pages, output ready);
endinterface

FILE: sv/bpa_map_ram.sv
module bpa_map_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int AWIDTH = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AWIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [AWIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/bitmap_page_allocator.sv
// Bitmap page allocator, next-fit.
// req_chan carries one word per operation: allocate, free or reserve a page run.
// rsp_chan returns one word per operation: status, first page, free page count.
// csr_chan writes managed_pages; write it only while the block is idle.
// The used map sits in a one-read one-write RAM of MAX_PAGES/WORD_BITS words.
// A shared bit-serial scan unit walks the map one page per clock; crossing into
// a new map word passes through the load state for the registered RAM read.
// Allocate makes an upper scan from the cursor, a lower scan from page 0 if
// that misses, then a mark pass over the run. Free checks the range, then
// clears it; reserve makes one pass. A scan pass over an empty range skips
// the map read. Error cases (zero count, bad range) go from idle to done.
// One operation at a time: req ready is high only while the sequencer is idle.
// Results sit in an output register, so the next request is taken while a
// result waits; a finished operation holds there until rsp_chan drains.
// Reset: sequencer, cursor, used count and response valid clear, managed_pages
// returns to 65536, then a clearing pass zeroes every map word, req ready low.
// CSR writes are always taken.
module bitmap_page_allocator #(
   parameter int MAX_PAGES = 65536,
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   bpa_req_if.sink     req_chan,
   bpa_rsp_if.source   rsp_chan,
   bpa_csr_if.sink     csr_chan
);
   import bpa_pkg::*;

   localparam int NW  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int MW  = (NW > 1) ? $clog2(NW) : 1;
   localparam int WL  = $clog2(WORD_BITS);
   localparam int PW  = $clog2(MAX_PAGES) + 1;
   localparam int AW  = (PW > COUNT_WIDTH + 1) ? PW : COUNT_WIDTH + 1;
   localparam logic [AW-1:0] MAX_A = AW'(MAX_PAGES);

   typedef enum logic [2:0] {
      ST_CLR, ST_IDLE, ST_FETCH, ST_LOAD, ST_PROC, ST_NEXT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_SCAN1, PH_SCAN2, PH_MARK, PH_CHECK, PH_CLEAR, PH_RES
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [AW-1:0]          p_ff, p_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          run_ff, run_in;
   logic [AW-1:0]          start_ff, start_in;
   logic [AW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          pi_ff, pi_in;
   logic [AW-1:0]          m_ff, m_in;
   logic [AW-1:0]          cursor_ff, cursor_in;
   logic [AW-1:0]          used_ff, used_in;
   logic                   hit_ff, hit_in;
   logic                   single_ff, single_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic                   dirty_ff, dirty_in;
   logic [MW-1:0]          clr_ff, clr_in;
   status_type             status_ff, status_in;
   logic [AW-1:0]          first_ff, first_in;
   logic [COUNT_WIDTH-1:0] managed_ff, managed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [INDEX_WIDTH-1:0] rsp_first_ff, rsp_first_in;
   logic [COUNT_WIDTH-1:0] rsp_free_ff, rsp_free_in;

   logic                   mem_we;
   logic [MW-1:0]          mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic [MW-1:0]          mem_raddr;
   logic [WORD_BITS-1:0]   mem_rdata;
   logic                   req_fire;

   bpa_map_ram #(.DEPTH(NW), .WIDTH(WORD_BITS), .AWIDTH(MW)) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_fire            = req_chan.valid && req_chan.ready;
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.first_page = rsp_first_ff;
   assign rsp_chan.free_pages = rsp_free_ff;

   always_comb begin
      logic          bit_v;
      logic          done_v;
      logic [AW-1:0] p_nx;
      logic [AW-1:0] m_v;
      logic [AW-1:0] lo_v;
      logic [AW-1:0] end_v;
      logic [AW-1:0] hi2_v;

      state_in      = state_ff;
      phase_in      = phase_ff;
      p_in          = p_ff;
      hi_in         = hi_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      pi_in         = pi_ff;
      m_in          = m_ff;
      cursor_in     = cursor_ff;
      used_in       = used_ff;
      hit_in        = hit_ff;
      single_in     = single_ff;
      word_in       = word_ff;
      dirty_in      = dirty_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      managed_in    = managed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_free_in   = rsp_free_ff;
      mem_we        = 1'b0;
      mem_waddr     = p_ff[WL +: MW];
      mem_wdata     = word_ff;
      mem_raddr     = p_ff[WL +: MW];
      bit_v         = 1'b0;
      done_v        = 1'b0;
      p_nx          = p_ff + AW'(1);
      m_v           = (AW'(managed_ff) > MAX_A) ? MAX_A : AW'(managed_ff);
      lo_v          = '0;
      end_v         = start_ff + cnt_ff;
      hi2_v         = '0;

      if (csr_chan.valid) begin
         managed_in = csr_chan.managed_pages;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + MW'(1);
            if (clr_ff == MW'(NW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in    = AW'(req_chan.page_count);
               pi_in     = AW'(req_chan.start_page);
               single_in = (req_chan.page_count == COUNT_WIDTH'(1));
               m_in      = m_v;
               status_in = STATUS_OK;
               first_in  = '0;
               run_in    = '0;
               hit_in    = 1'b0;
               state_in  = ST_DONE;
               case (req_chan.operation)
                  OP_ALLOC: begin
                     if (req_chan.page_count == '0) begin
                        status_in = STATUS_BAD_RANGE;
                     end else begin
                        // single-page search restarts at 0 once the cursor is past the top
                        lo_v = (req_chan.page_count == COUNT_WIDTH'(1) && cursor_ff >= m_v)
                               ? '0 : cursor_ff;
                        phase_in = PH_SCAN1;
                        p_in     = lo_v;
                        hi_in    = m_v;
                        state_in = (lo_v < m_v) ? ST_FETCH : ST_NEXT;
                     end
                  end
                  OP_FREE: begin
                     end_v = AW'(req_chan.start_page) + AW'(req_chan.page_count);
                     if (req_chan.page_count == '0 || end_v > m_v) begin
                        status_in = STATUS_BAD_RANGE;
                     end else begin
                        phase_in = PH_CHECK;
                        p_in     = AW'(req_chan.start_page);
                        hi_in    = end_v;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_RESERVE: begin
                     end_v = AW'(req_chan.start_page) + AW'(req_chan.page_count);
                     if (req_chan.page_count != '0 && AW'(req_chan.start_page) < m_v) begin
                        phase_in = PH_RES;
                        p_in     = AW'(req_chan.start_page);
                        hi_in    = (end_v > m_v) ? m_v : end_v;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     status_in = STATUS_BAD_RANGE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            word_in  = mem_rdata;
            dirty_in = 1'b0;
            state_in = ST_PROC;
         end
         ST_PROC: begin
            bit_v = word_ff[p_ff[WL-1:0]];
            case (phase_ff)
               PH_SCAN1, PH_SCAN2: begin
                  if (!bit_v) begin
                     run_in = run_ff + AW'(1);
                     if (run_ff + AW'(1) == cnt_ff) begin
                        hit_in   = 1'b1;
                        start_in = p_nx - cnt_ff;
                        done_v   = 1'b1;
                     end
                  end else begin
                     run_in = '0;
                  end
               end
               PH_MARK: begin
                  word_in[p_ff[WL-1:0]] = 1'b1;
                  dirty_in              = 1'b1;
               end
               PH_CHECK: begin
                  if (!bit_v) begin
                     hit_in = 1'b1;
                     done_v = 1'b1;
                  end
               end
               PH_CLEAR: begin
                  word_in[p_ff[WL-1:0]] = 1'b0;
                  dirty_in              = 1'b1;
               end
               PH_RES: begin
                  if (!bit_v) begin
                     word_in[p_ff[WL-1:0]] = 1'b1;
                     dirty_in              = 1'b1;
                     used_in               = used_ff + AW'(1);
                  end
               end
               default: begin
               end
            endcase
            mem_wdata = word_in;
            p_in      = p_nx;
            if (done_v || p_nx == hi_ff) begin
               mem_we   = dirty_in;
               state_in = ST_NEXT;
            end else if (p_nx[WL +: MW] != p_ff[WL +: MW] || p_nx[AW-1:WL] != p_ff[AW-1:WL]) begin
               // word boundary: write back and fetch the next word together
               mem_we    = dirty_in;
               mem_raddr = p_nx[WL +: MW];
               state_in  = ST_LOAD;
            end
         end
         ST_NEXT: begin
            case (phase_ff)
               PH_SCAN1: begin
                  if (hit_ff) begin
                     phase_in = PH_MARK;
                     p_in     = start_ff;
                     hi_in    = end_v;
                     state_in = ST_FETCH;
                  end else begin
                     if (single_ff) begin
                        hi2_v = (cursor_ff < m_ff) ? cursor_ff : '0;
                     end else begin
                        hi2_v = (cursor_ff < m_ff) ? cursor_ff : m_ff;
                     end
                     phase_in = PH_SCAN2;
                     p_in     = '0;
                     hi_in    = hi2_v;
                     run_in   = '0;
                     hit_in   = 1'b0;
                     state_in = (hi2_v != '0) ? ST_FETCH : ST_NEXT;
                  end
               end
               PH_SCAN2: begin
                  if (hit_ff) begin
                     phase_in = PH_MARK;
                     p_in     = start_ff;
                     hi_in    = end_v;
                     state_in = ST_FETCH;
                  end else begin
                     status_in = STATUS_NO_RUN;
                     state_in  = ST_DONE;
                  end
               end
               PH_MARK: begin
                  used_in = used_ff + cnt_ff;
                  if (single_ff) begin
                     cursor_in = (end_v >= m_ff) ? '0 : end_v;
                  end else begin
                     cursor_in = end_v;
                  end
                  first_in = start_ff;
                  state_in = ST_DONE;
               end
               PH_CHECK: begin
                  if (hit_ff) begin
                     status_in = STATUS_DOUBLE_FREE;
                     state_in  = ST_DONE;
                  end else begin
                     phase_in = PH_CLEAR;
                     p_in     = pi_ff;
                     hi_in    = pi_ff + cnt_ff;
                     state_in = ST_FETCH;
                  end
               end
               PH_CLEAR: begin
                  used_in = used_ff - cnt_ff;
                  if (pi_ff < cursor_ff) begin
                     cursor_in = pi_ff;
                  end
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_first_in  = first_ff[INDEX_WIDTH-1:0];
               rsp_free_in   = (m_ff > used_ff) ? COUNT_WIDTH'(m_ff - used_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         used_ff      <= '0;
         managed_ff   <= MANAGED_RESET;
         rsp_valid_ff <= 1'b0;
         dirty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         managed_ff   <= managed_in;
         rsp_valid_ff <= rsp_valid_in;
         dirty_ff     <= dirty_in;
      end
      phase_ff      <= phase_in;
      p_ff          <= p_in;
      hi_ff         <= hi_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      cnt_ff        <= cnt_in;
      pi_ff         <= pi_in;
      m_ff          <= m_in;
      hit_ff        <= hit_in;
      single_ff     <= single_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      first_ff      <= first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // used count can never pass the map size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= MAX_A)
      else $error("used count past map size");

   // the scan pointer stays inside the current pass range
   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROC |-> p_ff < hi_ff)
      else $error("scan pointer outside pass");

   // map writes only come from the clearing pass or the scan unit
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLR || state_ff == ST_PROC))
      else $error("unexpected map write");

   // a result held under stall stays valid and keeps its free page count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_free_ff))
      else $error("result dropped under stall");
endmodule
